### sv/modular_exponentiation_top_assert.svh
// assertion macros for the modular exponentiation checker
// no dependencies; included by the checker module file
`ifndef MODULAR_EXPONENTIATION_TOP_ASSERT_SVH
`define MODULAR_EXPONENTIATION_TOP_ASSERT_SVH

// same-cycle implication, gated by reset
`define MEX_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("modexp assertion failed");

// next-cycle implication, gated by reset
`define MEX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("modexp assertion failed");

`endif

### sv/mex_pkg.sv
// shared constants and item types for the modular exponentiation block
// no dependencies
package mex_pkg;

    localparam int OPERAND_BITS = 32;
    localparam int CNT_BITS     = $clog2(OPERAND_BITS);
    localparam int RESULT_BITS  = 32;

    typedef struct packed {
        logic [OPERAND_BITS-1:0] base_value;
        logic [OPERAND_BITS-1:0] exponent;
        logic [OPERAND_BITS-1:0] modulus;
    } t_in_item;

    typedef struct packed {
        logic [RESULT_BITS-1:0] power_result;
        logic                   bad_modulus;
    } t_out_item;

endpackage

### sv/modular_exponentiation_top.sv
// modular exponentiation, right-to-left square-and-multiply
// depends on mex_pkg
// usage:
//  - drive i_item and raise start; the item is taken at a rising edge
//    where start is high and busy is low
//  - the result appears on o_result for exactly one cycle with o_done high;
//    the receiver cannot stall, so it must take the item in that cycle
//  - a zero modulus is answered on the next cycle with power_result 0 and
//    bad_modulus set, and busy never rises
//  - otherwise busy stays high until the result cycle
// sequence:
//  - the base is first reduced, then each exponent bit takes a select step,
//    a multiply into the running result when the bit is set, and a squaring
//    of the base power; o_done follows the last squaring
//  - all of this work runs on the single bit-serial modular multiplier, which
//    consumes one multiplier bit per cycle and is shared by every product
//  - one item at a time; a new start is taken in the result cycle
// reset:
//  - synchronous, active low; returns to idle and drops busy and o_done
module modular_exponentiation_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  mex_pkg::t_in_item   i_item,
    output logic                busy,
    output logic                o_done,
    output mex_pkg::t_out_item  o_result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED,
        ST_SEL,
        ST_MUL,
        ST_SQR
    } t_state;

    localparam int W = mex_pkg::OPERAND_BITS;
    localparam int C = mex_pkg::CNT_BITS;

    t_state             r_state;
    logic               r_busy;
    logic               r_done;
    mex_pkg::t_out_item r_result;

    // operand and working registers
    logic [W-1:0] r_mod;     // modulus
    logic [W-1:0] r_exp;     // exponent, shifted right one bit per step
    logic [W-1:0] r_acc;     // running result
    logic [W-1:0] r_b;       // current base power, always below the modulus
    logic [W-1:0] r_mplier;  // multiplier, consumed msb first
    logic [W-1:0] r_mcand;   // multiplicand, below the modulus
    logic [W-1:0] r_prod;    // partial product, below the modulus
    logic [C-1:0] r_cnt;     // bit count inside one multiplication
    logic [C-1:0] r_exp_cnt; // exponent bit index

    // one bit step of the interleaved multiplier:
    // t = 2*prod + bit*mcand stays below 3*mod, so one of t, t-mod, t-2*mod fits
    logic [W+1:0] t_sum;
    logic [W+1:0] mod_x1;
    logic [W+1:0] mod_x2;
    logic [W-1:0] n_prod;
    logic         n_done;
    logic         mul_last;
    logic         exp_last;
    logic         accept;

    assign mod_x1 = {2'b00, r_mod};
    assign mod_x2 = {1'b0, r_mod, 1'b0};
    assign t_sum  = {1'b0, r_prod, 1'b0}
                  + (r_mplier[W-1] ? {2'b00, r_mcand} : '0);

    always_comb begin
        if (t_sum >= mod_x2) begin
            n_prod = W'(t_sum - mod_x2);
        end else if (t_sum >= mod_x1) begin
            n_prod = W'(t_sum - mod_x1);
        end else begin
            n_prod = W'(t_sum);
        end
    end

    assign mul_last = (r_cnt == C'(W - 1));
    assign exp_last = (r_exp_cnt == C'(W - 1));
    assign accept   = start && !r_busy;

    // result strobe: zero modulus right away, else after the last squaring
    assign n_done = ((r_state == ST_IDLE) && accept && (i_item.modulus == '0))
                 || ((r_state == ST_SQR) && mul_last && exp_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= n_done;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_mod     <= i_item.modulus;
                        r_exp     <= i_item.exponent;
                        r_exp_cnt <= '0;
                        if (i_item.modulus == '0) begin
                            // zero modulus: flagged right away
                            r_result.power_result <= '0;
                            r_result.bad_modulus  <= 1'b1;
                        end else begin
                            // reduce the base: base * 1 mod m
                            r_acc    <= W'(1);
                            r_mplier <= i_item.base_value;
                            r_mcand  <= W'(1);
                            r_prod   <= '0;
                            r_cnt    <= '0;
                            r_busy   <= 1'b1;
                            r_state  <= ST_RED;
                        end
                    end
                end
                ST_RED: begin
                    r_prod   <= n_prod;
                    r_mplier <= r_mplier << 1;
                    r_cnt    <= r_cnt + C'(1);
                    if (mul_last) begin
                        r_b     <= n_prod;
                        r_state <= ST_SEL;
                    end
                end
                ST_SEL: begin
                    r_prod <= '0;
                    r_cnt  <= '0;
                    if (r_exp[0]) begin
                        r_mplier <= r_acc;
                        r_mcand  <= r_b;
                        r_state  <= ST_MUL;
                    end else begin
                        r_mplier <= r_b;
                        r_mcand  <= r_b;
                        r_state  <= ST_SQR;
                    end
                end
                ST_MUL: begin
                    r_cnt <= r_cnt + C'(1);
                    if (mul_last) begin
                        // multiply done, square the base power next
                        r_acc    <= n_prod;
                        r_prod   <= '0;
                        r_mplier <= r_b;
                        r_mcand  <= r_b;
                        r_state  <= ST_SQR;
                    end else begin
                        r_prod   <= n_prod;
                        r_mplier <= r_mplier << 1;
                    end
                end
                ST_SQR: begin
                    r_prod   <= n_prod;
                    r_mplier <= r_mplier << 1;
                    r_cnt    <= r_cnt + C'(1);
                    if (mul_last) begin
                        r_b   <= n_prod;
                        r_exp <= r_exp >> 1;
                        if (exp_last) begin
                            r_result.power_result <= mex_pkg::RESULT_BITS'(r_acc);
                            r_result.bad_modulus  <= 1'b0;
                            r_busy                <= 1'b0;
                            r_state               <= ST_IDLE;
                        end else begin
                            r_exp_cnt <= r_exp_cnt + C'(1);
                            r_state   <= ST_SEL;
                        end
                    end
                end
                default: begin
                    r_busy  <= 1'b0;
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy     = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### sv/mex_checker.sv
// port-level checks for modular_exponentiation_top, with its bind
// depends on mex_pkg and modular_exponentiation_top_assert.svh
`include "modular_exponentiation_top_assert.svh"

module mex_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input mex_pkg::t_in_item  i_item,
    input logic               busy,
    input logic               o_done,
    input mex_pkg::t_out_item o_result
);

    logic take_item;
    logic zero_mod;
    logic err_answer;

    assign take_item  = start && !busy;
    assign zero_mod   = (i_item.modulus == '0);
    assign err_answer = o_done && o_result.bad_modulus && (o_result.power_result == '0);

    // a nonzero modulus item keeps the block busy
    `MEX_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, take_item && !zero_mod, busy)

    // a zero modulus item is answered on the next cycle with the error flag
    `MEX_ASSERT_NEXT(a_zero_mod_answer, i_clk, i_rst_n, take_item && zero_mod, err_answer)

    // whenever busy drops, a result is delivered in that cycle
    `MEX_ASSERT_NOW(a_fall_with_done, i_clk, i_rst_n, $fell(busy), o_done)

    // no result while still busy
    `MEX_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n, o_done, !busy)

endmodule

bind modular_exponentiation_top mex_checker u_mex_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
